// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL; empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_AT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define ASSERT_CLK(label, prop) `ASSERT_AT(label, clk_i, rst_ni, prop)
`else
`define ASSERT_AT(label, clk, rstn, prop)
`define ASSERT_CLK(label, prop)
`endif
`endif

// ===== rtl/core/latu_pkg.sv =====
// Types and constants of the Latin-1 / UTF-8 transcoder.
package latu_pkg;

  localparam int unsigned CountW = 31;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] CfgIdxDirection = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgIdxNoError   = 1'b1;

  localparam logic [7:0] LeadMark   = 8'hC0;
  localparam logic [7:0] ContMark   = 8'h80;
  localparam logic [7:0] SixMask    = 8'h3F;
  localparam logic [7:0] FiveMask   = 8'h1F;
  localparam logic [7:0] ContHigh   = 8'hBF;
  localparam logic [7:0] LeadMin    = 8'hC2;
  localparam logic [7:0] LeadMax    = 8'hF4;
  localparam logic [7:0] Lead3Min   = 8'hE0;
  localparam logic [7:0] Lead4Min   = 8'hF0;
  localparam logic [7:0] Latin1Lead = 8'hC3;

  typedef enum logic [1:0] {
    PhNormal = 2'd0,
    PhSeq    = 2'd1,
    PhFault  = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    StopDone    = 2'd0,
    StopInvalid = 2'd1,
    StopUntrans = 2'd2
  } reason_e;

  typedef enum logic {
    DirToUtf8   = 1'b0,
    DirToLatin1 = 1'b1
  } dir_e;

  typedef struct packed {
    logic [7:0]        byte0;
    logic [7:0]        byte1;
    logic [1:0]        ndata;
    logic              has_end;
    reason_e           reason;
    logic              err;
    logic [CountW-1:0] count;
  } bundle_t;

  typedef struct packed {
    logic              is_end;
    logic [7:0]        out_byte;
    logic              last_of_run;
    logic [1:0]        stop_reason;
    logic              error_raised;
    logic [CountW-1:0] converted_count;
  } item_t;

endpackage

// ===== rtl/core/latu_if.sv =====
// Valid/ready stream interfaces for the transcoder input and result channels.
interface latu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       is_final;

  modport source (output valid, output in_byte, output is_final, input ready);
  modport sink   (input valid, input in_byte, input is_final, output ready);
endinterface

interface latu_out_if;
  logic        valid;
  logic        ready;
  logic        is_end;
  logic [7:0]  out_byte;
  logic        last_of_run;
  logic [1:0]  stop_reason;
  logic        error_raised;
  logic [30:0] converted_count;

  modport source (
    output valid, output is_end, output out_byte, output last_of_run,
    output stop_reason, output error_raised, output converted_count,
    input ready
  );
  modport sink (
    input valid, input is_end, input out_byte, input last_of_run,
    input stop_reason, input error_raised, input converted_count,
    output ready
  );
endinterface

// ===== rtl/core/latu_step.sv =====
// Per-byte sequence state and conversion logic producing a result bundle.
module latu_step
  import latu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dir_e       dir_i,
  input  logic       no_error_i,
  input  logic       fire_i,
  input  logic [7:0] byte_i,
  input  logic       final_i,
  output bundle_t    bundle_o
);

  phase_e            phase_q, phase_d;
  logic [7:0]        lead_q, lead_d;
  logic [2:0]        len_q, len_d;
  logic [2:0]        seen_q, seen_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  reason_e           fault_q, fault_d;

  logic [1:0]        add;
  logic [CountW:0]   sum;
  logic [7:0]        lo, hi;
  logic [CountW-1:0] cnt_step;

  always_comb begin
    phase_d  = phase_q;
    lead_d   = lead_q;
    len_d    = len_q;
    seen_d   = seen_q;
    fault_d  = fault_q;
    add      = 2'd0;
    lo       = ContMark;
    hi       = ContHigh;
    bundle_o = '0;
    bundle_o.reason = StopDone;

    if (phase_q == PhFault) begin
    end else if (dir_i == DirToUtf8) begin
      phase_d = PhNormal;
      if (byte_i == 8'h00) begin
        phase_d = PhFault;
        fault_d = StopInvalid;
      end else if (byte_i < ContMark) begin
        bundle_o.byte0 = byte_i;
        bundle_o.ndata = 2'd1;
        add = 2'd1;
      end else begin
        bundle_o.byte0 = LeadMark | (byte_i >> 6);
        bundle_o.byte1 = ContMark | (byte_i & SixMask);
        bundle_o.ndata = 2'd2;
        add = 2'd1;
      end
    end else if (phase_q == PhNormal) begin
      if (byte_i == 8'h00) begin
        phase_d = PhFault;
        fault_d = StopInvalid;
      end else if (byte_i < ContMark) begin
        bundle_o.byte0 = byte_i;
        bundle_o.ndata = 2'd1;
        add = 2'd1;
      end else if (byte_i < LeadMin || byte_i > LeadMax) begin
        phase_d = PhFault;
        fault_d = StopInvalid;
      end else begin
        lead_d  = byte_i;
        len_d   = (byte_i < Lead3Min) ? 3'd2 : (byte_i < Lead4Min) ? 3'd3 : 3'd4;
        seen_d  = 3'd1;
        phase_d = PhSeq;
      end
    end else begin
      if (seen_q == 3'd1) begin
        case (lead_q)
          8'hE0:   lo = 8'hA0;
          8'hED:   hi = 8'h9F;
          8'hF0:   lo = 8'h90;
          8'hF4:   hi = 8'h8F;
          default: lo = ContMark;
        endcase
      end
      if (byte_i < lo || byte_i > hi) begin
        phase_d = PhFault;
        fault_d = StopInvalid;
      end else begin
        seen_d = seen_q + 3'd1;
        if (seen_d >= len_q) begin
          phase_d = PhNormal;
          if (len_q == 3'd2 && lead_q <= Latin1Lead) begin
            bundle_o.byte0 = ((lead_q & FiveMask) << 6) | (byte_i & SixMask);
            bundle_o.ndata = 2'd1;
            add = 2'd2;
          end else begin
            phase_d = PhFault;
            fault_d = StopUntrans;
          end
        end
      end
    end

    sum      = {1'b0, cnt_q} + {{(CountW-1){1'b0}}, add};
    cnt_step = sum[CountW] ? {CountW{1'b1}} : sum[CountW-1:0];
    cnt_d    = cnt_step;

    if (final_i) begin
      bundle_o.has_end = 1'b1;
      bundle_o.reason  = (phase_d == PhFault) ? fault_d :
                         (phase_d == PhSeq) ? StopInvalid : StopDone;
      bundle_o.err     = (bundle_o.reason != StopDone) && !no_error_i;
      bundle_o.count   = cnt_step;
      phase_d = PhNormal;
      lead_d  = 8'h00;
      len_d   = 3'd0;
      seen_d  = 3'd0;
      cnt_d   = '0;
      fault_d = StopDone;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhNormal;
      lead_q  <= 8'h00;
      len_q   <= 3'd0;
      seen_q  <= 3'd0;
      cnt_q   <= '0;
      fault_q <= StopDone;
    end else if (fire_i) begin
      phase_q <= phase_d;
      lead_q  <= lead_d;
      len_q   <= len_d;
      seen_q  <= seen_d;
      cnt_q   <= cnt_d;
      fault_q <= fault_d;
    end
  end

endmodule

// ===== rtl/core/latu_emit.sv =====
// Result register that hands out the items of one bundle, one per transfer.
module latu_emit
  import latu_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  bundle_t bundle_i,
  output logic    can_load_o,
  output logic    valid_o,
  input  logic    ready_i,
  output item_t   item_o
);

  bundle_t    bun_q;
  logic       valid_q;
  logic [1:0] idx_q;
  logic [1:0] items;
  logic [1:0] items_in;
  logic       last;
  logic       data_item;

  assign items      = bun_q.ndata + {1'b0, bun_q.has_end};
  assign items_in   = bundle_i.ndata + {1'b0, bundle_i.has_end};
  assign last       = (idx_q == items - 2'd1);
  assign data_item  = (idx_q < bun_q.ndata);
  assign can_load_o = !valid_q || (ready_i && last);
  assign valid_o    = valid_q;

  always_comb begin
    item_o = '0;
    item_o.last_of_run = last;
    if (data_item) begin
      item_o.out_byte = (idx_q == 2'd0) ? bun_q.byte0 : bun_q.byte1;
    end else begin
      item_o.is_end          = 1'b1;
      item_o.stop_reason     = bun_q.reason;
      item_o.error_raised    = bun_q.err;
      item_o.converted_count = bun_q.count;
    end
  end

  always_ff @(posedge clk_i) begin
    if (can_load_o && load_i) begin
      bun_q <= bundle_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else if (can_load_o) begin
      valid_q <= load_i && (items_in != 2'd0);
      idx_q   <= 2'd0;
    end else if (ready_i) begin
      idx_q <= idx_q + 2'd1;
    end
  end

endmodule

// ===== rtl/core/latin1_utf8_transcoder.sv =====
// Top level of the Latin-1 / UTF-8 byte-stream transcoder.
// Takes one source byte per transfer and returns zero to three result items:
// converted data bytes and, on the byte marked final, an end item with the stop
// reason, error flag, converted byte count and a zero terminator. A byte is
// registered at its input transfer and its results are loaded into the result
// register once it can take them. A new byte is accepted every cycle while each
// byte yields at most one result and the result port is ready; a byte with two
// or three results holds the input until the single result port has taken them.
// Write direction and no_error only while no string is in flight.
`include "assert_macros.svh"

module latin1_utf8_transcoder
  import latu_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic               cfg_data_i,
  latu_in_if.sink            in_i,
  latu_out_if.source         out_o
);

  dir_e       dir_q;
  logic       no_error_q;
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_final_q;
  logic       take;
  logic       fire;
  bundle_t    bundle;
  item_t      item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q      <= DirToUtf8;
      no_error_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgIdxDirection: dir_q      <= dir_e'(cfg_data_i);
        CfgIdxNoError:   no_error_q <= cfg_data_i;
        default:         no_error_q <= no_error_q;
      endcase
    end
  end

  assign in_i.ready = !in_valid_q || take;
  assign fire       = in_valid_q && take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (take) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_byte_q  <= in_i.in_byte;
      in_final_q <= in_i.is_final;
    end
  end

  latu_step u_step (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .dir_i      (dir_q),
    .no_error_i (no_error_q),
    .fire_i     (fire),
    .byte_i     (in_byte_q),
    .final_i    (in_final_q),
    .bundle_o   (bundle)
  );

  latu_emit u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (fire),
    .bundle_i   (bundle),
    .can_load_o (take),
    .valid_o    (out_o.valid),
    .ready_i    (out_o.ready),
    .item_o     (item)
  );

  assign out_o.is_end          = item.is_end;
  assign out_o.out_byte        = item.out_byte;
  assign out_o.last_of_run     = item.last_of_run;
  assign out_o.stop_reason     = item.stop_reason;
  assign out_o.error_raised    = item.error_raised;
  assign out_o.converted_count = item.converted_count;

  `ASSERT_CLK(a_in_hold, in_valid_q && !take |=> in_valid_q && $stable(in_byte_q))
  `ASSERT_CLK(a_data_clean, out_o.valid && !out_o.is_end |-> out_o.stop_reason == 2'd0 && out_o.converted_count == '0 && !out_o.error_raised)
  `ASSERT_CLK(a_err_reason, out_o.valid && out_o.error_raised |-> out_o.is_end && out_o.stop_reason != 2'd0 && !no_error_q)
  `ASSERT_CLK(a_end_last, out_o.valid && out_o.is_end |-> out_o.last_of_run && out_o.out_byte == 8'h00)

endmodule
